// ----- rtl/sci_pkg.sv -----
// Shared types and constants of the serial command interpreter.
// Depends on nothing; every other file but sci_if.sv refers to it by scoped names.
package sci_pkg;

  // Line buffer geometry.
  localparam int unsigned LineLen = 5;
  localparam int unsigned CntW    = $clog2(LineLen + 1);
  localparam int unsigned IdxW    = $clog2(LineLen);

  // Command queue between the front and back parts.
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  // Characters and command texts, first character in the top byte.
  localparam logic [7:0]  CharCr    = 8'd13;
  localparam logic [7:0]  CharZero  = 8'h30;
  localparam logic [7:0]  CharNine  = 8'h39;
  localparam logic [39:0] TxtRnack  = "RNACK";
  localparam logic [31:0] TxtRack   = "RACK";
  localparam logic [39:0] TxtDebug  = "DEBUG";
  localparam logic [31:0] TxtRstc   = "RSTC";
  localparam logic [31:0] TxtRsts   = "RSTS";
  localparam logic [23:0] TxtUl     = "UL ";
  localparam logic [23:0] TxtUu     = "UU ";
  localparam logic [23:0] TxtTw     = "TW ";
  localparam logic [23:0] TxtRt     = "RT ";

  // Setting limits (exclusive upper bounds).
  localparam logic [6:0] UpperEnd  = 7'd20;
  localparam logic [6:0] WindowEnd = 7'd5;
  localparam logic [6:0] ReportEnd = 7'd10;

  // Setting reset values.
  localparam logic [4:0] LowerRst  = 5'd5;
  localparam logic [4:0] UpperRst  = 5'd15;
  localparam logic [2:0] WindowRst = 3'd3;
  localparam logic [3:0] ReportRst = 4'd5;

  // Reply codes.
  localparam logic [3:0] RepRdy     = 4'd0;
  localparam logic [3:0] RepHshk    = 4'd1;
  localparam logic [3:0] RepNotEst  = 4'd2;
  localparam logic [3:0] RepCack    = 4'd3;
  localparam logic [3:0] RepSack    = 4'd4;
  localparam logic [3:0] RepRange   = 4'd5;
  localparam logic [3:0] RepLower   = 4'd6;
  localparam logic [3:0] RepUpper   = 4'd7;
  localparam logic [3:0] RepWindow  = 4'd8;
  localparam logic [3:0] RepReport  = 4'd9;
  localparam logic [3:0] RepInvalid = 4'd10;

  // Command class found by the front part.
  typedef enum logic [3:0] {
    CmdRnack,
    CmdRack,
    CmdDebug,
    CmdRstc,
    CmdRsts,
    CmdSetLower,
    CmdSetUpper,
    CmdSetWindow,
    CmdSetReport,
    CmdInvalid
  } cmd_e;

  // One queued command: its class and the decoded setting value.
  typedef struct packed {
    cmd_e       kind;
    logic [6:0] num;
  } cmd_t;

endpackage

// ----- rtl/sci_if.sv -----
// Handshake channels of the serial command interpreter.
// Depends on nothing beyond plain logic types.
interface sci_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sci_reply_if;
  logic       valid;
  logic       ready;
  logic [3:0] reply_code;
  logic [6:0] reply_value;
  logic       link_established;
  logic       reset_request;
  logic       standby_request;
  logic [4:0] lower_limit_now;
  logic [4:0] upper_limit_now;
  logic [2:0] window_now;
  logic [3:0] report_now;

  modport source (output valid, output reply_code, output reply_value,
                  output link_established, output reset_request,
                  output standby_request, output lower_limit_now,
                  output upper_limit_now, output window_now,
                  output report_now, input ready);
  modport sink   (input valid, input reply_code, input reply_value,
                  input link_established, input reset_request,
                  input standby_request, input lower_limit_now,
                  input upper_limit_now, input window_now,
                  input report_now, output ready);
endinterface

// ----- rtl/sci_front.sv -----
// Front part: collects received characters into a line and classifies the
// line on carriage return. Depends on sci_pkg.
module sci_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_ready_o,
  input  logic          q_full_i,
  output logic          push_o,
  output sci_pkg::cmd_t push_cmd_o
);

  logic [7:0]               chars_q [sci_pkg::LineLen];
  logic [7:0]               chars_d [sci_pkg::LineLen];
  logic [sci_pkg::CntW-1:0] count_q, count_d;
  logic [sci_pkg::CntW-1:0] len;
  logic [39:0]              word;
  logic                     accept, is_cr;
  logic                     dig3, dig4;
  logic [3:0]               d3v, d4v;
  logic [6:0]               num;

  // Items are taken whenever the queue has room for a command.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_cr      = (in_byte_i == sci_pkg::CharCr);
  assign push_o     = accept && is_cr;

  // Length of the text up to the first zero byte.
  always_comb begin
    logic stop;
    stop = 1'b0;
    len  = '0;
    for (int i = 0; i < sci_pkg::LineLen; i++) begin
      if (!stop && (sci_pkg::CntW'(i) < count_q) && (chars_q[i] != 8'd0)) begin
        len = sci_pkg::CntW'(i + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  // First five characters, first one in the top byte.
  assign word = {chars_q[0], chars_q[1], chars_q[2], chars_q[3], chars_q[4]};

  // Decimal value from positions three and four.
  assign dig3 = (chars_q[3] >= sci_pkg::CharZero) && (chars_q[3] <= sci_pkg::CharNine);
  assign dig4 = (chars_q[4] >= sci_pkg::CharZero) && (chars_q[4] <= sci_pkg::CharNine);
  assign d3v  = 4'(chars_q[3] - sci_pkg::CharZero);
  assign d4v  = 4'(chars_q[4] - sci_pkg::CharZero);
  assign num  = dig4 ? (7'(d3v) * 7'd10 + 7'(d4v)) : 7'(d3v);

  // Classify the line; exact commands first, then setting prefixes.
  always_comb begin
    push_cmd_o.num = num;
    priority if (len == sci_pkg::CntW'(5) && word == sci_pkg::TxtRnack) begin
      push_cmd_o.kind = sci_pkg::CmdRnack;
    end else if (len == sci_pkg::CntW'(4) && word[39:8] == sci_pkg::TxtRack) begin
      push_cmd_o.kind = sci_pkg::CmdRack;
    end else if (len == sci_pkg::CntW'(5) && word == sci_pkg::TxtDebug) begin
      push_cmd_o.kind = sci_pkg::CmdDebug;
    end else if (len == sci_pkg::CntW'(4) && word[39:8] == sci_pkg::TxtRstc) begin
      push_cmd_o.kind = sci_pkg::CmdRstc;
    end else if (len == sci_pkg::CntW'(4) && word[39:8] == sci_pkg::TxtRsts) begin
      push_cmd_o.kind = sci_pkg::CmdRsts;
    end else if (len >= sci_pkg::CntW'(3) && dig3 && word[39:16] == sci_pkg::TxtUl) begin
      push_cmd_o.kind = sci_pkg::CmdSetLower;
    end else if (len >= sci_pkg::CntW'(3) && dig3 && word[39:16] == sci_pkg::TxtUu) begin
      push_cmd_o.kind = sci_pkg::CmdSetUpper;
    end else if (len >= sci_pkg::CntW'(3) && dig3 && word[39:16] == sci_pkg::TxtTw) begin
      push_cmd_o.kind = sci_pkg::CmdSetWindow;
    end else if (len >= sci_pkg::CntW'(3) && dig3 && word[39:16] == sci_pkg::TxtRt) begin
      push_cmd_o.kind = sci_pkg::CmdSetReport;
    end else begin
      push_cmd_o.kind = sci_pkg::CmdInvalid;
    end
  end

  // Line buffer update: store while not full, clear on carriage return.
  always_comb begin
    chars_d = chars_q;
    count_d = count_q;
    if (accept) begin
      if (is_cr) begin
        count_d = '0;
        for (int i = 0; i < sci_pkg::LineLen; i++) begin
          chars_d[i] = 8'd0;
        end
      end else if (count_q < sci_pkg::CntW'(sci_pkg::LineLen)) begin
        chars_d[count_q[sci_pkg::IdxW-1:0]] = in_byte_i;
        count_d = count_q + sci_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < sci_pkg::LineLen; i++) begin
        chars_q[i] <= 8'd0;
      end
    end else begin
      count_q <= count_d;
      chars_q <= chars_d;
    end
  end

endmodule

// ----- rtl/sci_queue.sv -----
// Short command queue that decouples the front and back parts.
// Depends on sci_pkg.
module sci_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sci_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sci_pkg::cmd_t pop_cmd_o
);

  sci_pkg::cmd_t             mem_q [sci_pkg::QDepth];
  logic [sci_pkg::QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [sci_pkg::QCntW-1:0] count_q;
  logic                      do_push, do_pop;

  assign full_o    = (count_q == sci_pkg::QCntW'(sci_pkg::QDepth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == sci_pkg::QPtrW'(sci_pkg::QDepth - 1)) ? '0
                    : wr_ptr_q + sci_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == sci_pkg::QPtrW'(sci_pkg::QDepth - 1)) ? '0
                    : rd_ptr_q + sci_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + sci_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - sci_pkg::QCntW'(1);
      end
    end
  end

endmodule

// ----- rtl/sci_back.sv -----
// Back part: executes queued commands against the kept settings and holds
// the reply item in an output register. Depends on sci_pkg.
module sci_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  sci_pkg::cmd_t cmd_i,
  output logic          pop_o,
  sci_reply_if.source   reply
);

  logic [4:0] lower_q, lower_d;
  logic [4:0] upper_q, upper_d;
  logic [2:0] window_q, window_d;
  logic [3:0] report_q, report_d;
  logic       hshk_q, hshk_d;
  logic       out_valid_q;
  logic [3:0] code_q, code_d;
  logic [6:0] value_q, value_d;
  logic       rst_req_q, rst_req_d;
  logic       stb_req_q, stb_req_d;
  logic       in_range;

  // Take a command when the output register is free or being drained.
  assign pop_o = !q_empty_i && (!out_valid_q || reply.ready);

  // Range check for the setting named by the command.
  always_comb begin
    unique case (cmd_i.kind)
      sci_pkg::CmdSetLower:  in_range = (cmd_i.num >= 7'd1) && (cmd_i.num < 7'(upper_q));
      sci_pkg::CmdSetUpper:  in_range = (cmd_i.num >= 7'(lower_q) + 7'd1)
                                        && (cmd_i.num < sci_pkg::UpperEnd);
      sci_pkg::CmdSetWindow: in_range = (cmd_i.num >= 7'd1) && (cmd_i.num < sci_pkg::WindowEnd);
      sci_pkg::CmdSetReport: in_range = (cmd_i.num >= 7'd1) && (cmd_i.num < sci_pkg::ReportEnd);
      default:               in_range = 1'b0;
    endcase
  end

  // Reply and next settings.
  always_comb begin
    lower_d   = lower_q;
    upper_d   = upper_q;
    window_d  = window_q;
    report_d  = report_q;
    hshk_d    = hshk_q;
    value_d   = 7'd0;
    rst_req_d = 1'b0;
    stb_req_d = 1'b0;
    code_d    = sci_pkg::RepInvalid;
    unique case (cmd_i.kind)
      sci_pkg::CmdRnack: code_d = sci_pkg::RepRdy;
      sci_pkg::CmdRack: begin
        code_d = sci_pkg::RepHshk;
        hshk_d = 1'b1;
      end
      sci_pkg::CmdDebug: begin
        code_d = sci_pkg::RepNotEst;
        hshk_d = 1'b0;
      end
      sci_pkg::CmdRstc: begin
        code_d    = sci_pkg::RepCack;
        rst_req_d = 1'b1;
      end
      sci_pkg::CmdRsts: begin
        code_d    = sci_pkg::RepSack;
        stb_req_d = 1'b1;
      end
      sci_pkg::CmdSetLower: begin
        code_d = sci_pkg::RepRange;
        if (in_range) begin
          code_d  = sci_pkg::RepLower;
          value_d = cmd_i.num;
          lower_d = 5'(cmd_i.num);
        end
      end
      sci_pkg::CmdSetUpper: begin
        code_d = sci_pkg::RepRange;
        if (in_range) begin
          code_d  = sci_pkg::RepUpper;
          value_d = cmd_i.num;
          upper_d = 5'(cmd_i.num);
        end
      end
      sci_pkg::CmdSetWindow: begin
        code_d = sci_pkg::RepRange;
        if (in_range) begin
          code_d   = sci_pkg::RepWindow;
          value_d  = cmd_i.num;
          window_d = 3'(cmd_i.num);
        end
      end
      sci_pkg::CmdSetReport: begin
        code_d = sci_pkg::RepRange;
        if (in_range) begin
          code_d   = sci_pkg::RepReport;
          value_d  = cmd_i.num;
          report_d = 4'(cmd_i.num);
        end
      end
      default: code_d = sci_pkg::RepInvalid;
    endcase
  end

  // Kept settings and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q     <= sci_pkg::LowerRst;
      upper_q     <= sci_pkg::UpperRst;
      window_q    <= sci_pkg::WindowRst;
      report_q    <= sci_pkg::ReportRst;
      hshk_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        lower_q  <= lower_d;
        upper_q  <= upper_d;
        window_q <= window_d;
        report_q <= report_d;
        hshk_q   <= hshk_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (reply.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Reply payload register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      code_q    <= code_d;
      value_q   <= value_d;
      rst_req_q <= rst_req_d;
      stb_req_q <= stb_req_d;
    end
  end

  assign reply.valid            = out_valid_q;
  assign reply.reply_code       = code_q;
  assign reply.reply_value      = value_q;
  assign reply.link_established = hshk_q;
  assign reply.reset_request    = rst_req_q;
  assign reply.standby_request  = stb_req_q;
  assign reply.lower_limit_now  = lower_q;
  assign reply.upper_limit_now  = upper_q;
  assign reply.window_now       = window_q;
  assign reply.report_now       = report_q;

endmodule

// ----- rtl/serial_command_interpreter.sv -----
// Serial command interpreter: one received byte per cycle enters the line
// collector while the queue has room; a carriage return pushes a command
// into a two-entry queue, whose head the executing stage's output register
// takes as one reply item. Classifier and executor are combinational: one
// item per cycle while the reply side is ready. Reset clears the line, the
// queue and the output, and loads the settings: lower 5, upper 15, window 3, report 5.
module serial_command_interpreter (
  input  logic        clk_i,
  input  logic        rst_ni,
  sci_rx_if.sink      rx_i,
  sci_reply_if.source reply_o
);

  logic          q_full, q_empty, push, pop;
  sci_pkg::cmd_t push_cmd, pop_cmd;

  // Line collection and classification.
  sci_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_byte_i  (rx_i.rx_byte),
    .in_ready_o (rx_i.ready),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  // Command queue.
  sci_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_cmd_o  (pop_cmd)
  );

  // Command execution and reply.
  sci_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .cmd_i     (pop_cmd),
    .pop_o     (pop),
    .reply     (reply_o)
  );

endmodule
